>>> hdl/ppq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_pkg
// Shared types and constants for the priority push-out port queues.
// ----------------------------------------------------------------------------
package ppq_pkg;

    localparam int LEN_W       = 11;
    localparam int ENTRY_W     = 12;
    localparam int PRIO_BIT    = 11;
    localparam int LIMIT_W     = 24;
    localparam int STATUS_W    = 3;
    localparam int PORT_W      = 2;
    localparam int DEF_NUM_PORTS   = 4;
    localparam int DEF_QUEUE_DEPTH = 1024;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'(1024 * 1024);
    localparam logic [LIMIT_W-1:0] MAX_BYTES   = 24'hFFFFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED     = 3'd0,
        ST_EVICTED    = 3'd1,
        ST_DROP_LIMIT = 3'd2,
        ST_DROP_FULL  = 3'd3,
        ST_DEQUEUED   = 3'd4,
        ST_EMPTY      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } fsm_t;

    // per-port chain control: shift toward head, write one cell
    typedef struct packed {
        logic shift;
        logic wr_en;
    } chain_ctl_t;

endpackage

>>> hdl/ppq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_cell
// One queue slot: load a broadcast word or take the neighbor's word.
// ----------------------------------------------------------------------------
module ppq_cell #(
    parameter int W = 12
) (
    input  logic         aclk,
    input  logic         load,
    input  logic         shift,
    input  logic [W-1:0] load_data,
    input  logic [W-1:0] nbr_data,
    output logic [W-1:0] q
);
    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (load) begin
            data_next = load_data;
        end else if (shift) begin
            data_next = nbr_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;
endmodule

>>> hdl/ppq_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_chain
// One port queue as a row of cells; cell 0 is the head.
// ----------------------------------------------------------------------------
module ppq_chain #(
    parameter int QUEUE_DEPTH = ppq_pkg::DEF_QUEUE_DEPTH,
    parameter int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                         aclk,
    input  ppq_pkg::chain_ctl_t          ctl,
    input  logic [IDX_W-1:0]             wr_idx,
    input  logic [ppq_pkg::ENTRY_W-1:0]  wr_data,
    output logic [ppq_pkg::ENTRY_W-1:0]  head
);
    import ppq_pkg::*;

    logic [ENTRY_W-1:0] cell_q [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic               sel;
        logic [ENTRY_W-1:0] nbr;
        assign sel = ctl.wr_en && (wr_idx == IDX_W'(i));
        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign nbr = cell_q[i];
        end else begin : g_mid
            assign nbr = cell_q[i+1];
        end
        ppq_cell #(.W(ENTRY_W)) u_cell (
            .aclk      (aclk),
            .load      (sel),
            .shift     (ctl.shift),
            .load_data (wr_data),
            .nbr_data  (nbr),
            .q         (cell_q[i])
        );
    end

    assign head = cell_q[0];
endmodule

>>> hdl/priority_pushout_port_queues_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_pushout_port_queues_top
// Per-port packet FIFOs with byte totals and priority push-out.
// ----------------------------------------------------------------------------
// Each port queue is a row of cells with the head in cell 0. Enqueues that
// fit, drops and dequeues finish in the cycle that accepts the input word,
// and their result word is registered at once. A high-priority enqueue over
// the byte limit evicts the newest low-priority entry: the queue is rotated
// through itself once, head to tail, one entry per cycle, and the matching
// entry is left out on its pass; the new entry is then appended at the tail.
// A per-port count of low-priority entries tells which low entry is the
// newest, so no backward search is needed. The next input word is taken
// while a result waits, as long as the output register is free or drains.
// The byte limit is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module priority_pushout_port_queues_top #(
    parameter int NUM_PORTS   = ppq_pkg::DEF_NUM_PORTS,
    parameter int QUEUE_DEPTH = ppq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppq_pkg::LIMIT_W-1:0]   cfg_byte_limit,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [ppq_pkg::PORT_W-1:0]    s_port,
    input  logic [ppq_pkg::LEN_W-1:0]     s_pkt_length,
    input  logic                          s_pkt_priority,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ppq_pkg::STATUS_W-1:0]  m_status,
    output logic [ppq_pkg::LEN_W-1:0]     m_evicted_length,
    output logic [ppq_pkg::LEN_W-1:0]     m_out_length,
    output logic                          m_out_priority,
    output logic [ppq_pkg::LIMIT_W-1:0]   m_port_bytes
);
    import ppq_pkg::*;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W  = $clog2(QUEUE_DEPTH * 2047 + 1);
    localparam int CMP_W  = (TOT_W + 1 > LIMIT_W) ? TOT_W + 1 : LIMIT_W;
    localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    // saturate a byte total to the output field
    function automatic logic [LIMIT_W-1:0] sat_bytes(input logic [TOT_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        return (ext > CMP_W'(MAX_BYTES)) ? MAX_BYTES : ext[LIMIT_W-1:0];
    endfunction

    // ---- state -------------------------------------------------------------
    fsm_t                  state_reg, state_next;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [CNT_W-1:0]      count_reg [NUM_PORTS];
    logic [CNT_W-1:0]      count_next [NUM_PORTS];
    logic [CNT_W-1:0]      low_reg [NUM_PORTS];
    logic [CNT_W-1:0]      low_next [NUM_PORTS];
    logic [TOT_W-1:0]      total_reg [NUM_PORTS];
    logic [TOT_W-1:0]      total_next [NUM_PORTS];

    logic [PIDX_W-1:0]     port_reg, port_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LEN_W-1:0]      evict_reg, evict_next;
    logic [CNT_W-1:0]      left_reg, left_next;
    logic [CNT_W-1:0]      seen_reg, seen_next;

    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [LEN_W-1:0]      m_evict_reg, m_evict_next;
    logic [LEN_W-1:0]      m_olen_reg, m_olen_next;
    logic                  m_oprio_reg, m_oprio_next;
    logic [LIMIT_W-1:0]    m_bytes_reg, m_bytes_next;

    // ---- chain control -----------------------------------------------------
    chain_ctl_t            ctl [NUM_PORTS];
    logic [ENTRY_W-1:0]    heads [NUM_PORTS];
    logic                  shift_en, wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [ENTRY_W-1:0]    wr_data;
    logic [PIDX_W-1:0]     cur_idx;
    logic [ENTRY_W-1:0]    cur_head;
    logic                  out_free;
    logic                  port_ok;
    logic [CMP_W-1:0]      sum_ext;

    for (genvar p = 0; p < NUM_PORTS; p++) begin : g_port
        assign ctl[p].shift = shift_en && (cur_idx == PIDX_W'(p));
        assign ctl[p].wr_en = wr_en && (cur_idx == PIDX_W'(p));
        ppq_chain #(.QUEUE_DEPTH(QUEUE_DEPTH), .IDX_W(IDX_W)) u_chain (
            .aclk    (aclk),
            .ctl     (ctl[p]),
            .wr_idx  (wr_idx),
            .wr_data (wr_data),
            .head    (heads[p])
        );
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && out_free;
    assign cfg_ready = 1'b1;
    assign port_ok   = 5'(s_port) < 5'(NUM_PORTS);
    assign cur_idx   = (state_reg == S_IDLE) ? PIDX_W'(s_port) : port_reg;
    assign cur_head  = heads[cur_idx];
    assign sum_ext   = CMP_W'(total_reg[cur_idx]) + CMP_W'(s_pkt_length);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        low_next      = low_reg;
        total_next    = total_reg;
        port_next     = port_reg;
        len_next      = len_reg;
        evict_next    = evict_reg;
        left_next     = left_reg;
        seen_next     = seen_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_evict_next  = m_evict_reg;
        m_olen_next   = m_olen_reg;
        m_oprio_next  = m_oprio_reg;
        m_bytes_next  = m_bytes_reg;
        shift_en      = 1'b0;
        wr_en         = 1'b0;
        wr_idx        = IDX_W'(count_reg[cur_idx]);
        wr_data       = {s_pkt_priority, s_pkt_length};

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    m_valid_next = 1'b1;
                    m_evict_next = '0;
                    m_olen_next  = '0;
                    m_oprio_next = 1'b0;
                    m_bytes_next = '0;
                    if (!port_ok) begin
                        // absent port: report and leave every queue alone
                        m_status_next = s_mode ? ST_EMPTY : ST_DROP_FULL;
                    end else if (s_mode) begin
                        if (count_reg[cur_idx] == '0) begin
                            m_status_next = ST_EMPTY;
                            m_bytes_next  = sat_bytes(total_reg[cur_idx]);
                        end else begin
                            // pop the head: every cell takes its neighbor
                            shift_en = 1'b1;
                            count_next[cur_idx] = count_reg[cur_idx] - 1'b1;
                            total_next[cur_idx] = total_reg[cur_idx]
                                - TOT_W'(cur_head[LEN_W-1:0]);
                            if (!cur_head[PRIO_BIT]) begin
                                low_next[cur_idx] = low_reg[cur_idx] - 1'b1;
                            end
                            m_status_next = ST_DEQUEUED;
                            m_olen_next   = cur_head[LEN_W-1:0];
                            m_oprio_next  = cur_head[PRIO_BIT];
                            m_bytes_next  = sat_bytes(total_next[cur_idx]);
                        end
                    end else if (sum_ext <= CMP_W'(limit_reg)) begin
                        if (count_reg[cur_idx] >= CNT_W'(QUEUE_DEPTH)) begin
                            m_status_next = ST_DROP_FULL;
                        end else begin
                            // append at the tail
                            wr_en = 1'b1;
                            count_next[cur_idx] = count_reg[cur_idx] + 1'b1;
                            total_next[cur_idx] = total_reg[cur_idx]
                                + TOT_W'(s_pkt_length);
                            if (!s_pkt_priority) begin
                                low_next[cur_idx] = low_reg[cur_idx] + 1'b1;
                            end
                            m_status_next = ST_QUEUED;
                        end
                        m_bytes_next = sat_bytes(total_next[cur_idx]);
                    end else if (!s_pkt_priority || low_reg[cur_idx] == '0) begin
                        m_status_next = ST_DROP_LIMIT;
                        m_bytes_next  = sat_bytes(total_reg[cur_idx]);
                    end else begin
                        // start the rotation pass; no result yet
                        m_valid_next = 1'b0;
                        port_next    = cur_idx;
                        len_next     = s_pkt_length;
                        left_next    = count_reg[cur_idx];
                        seen_next    = '0;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                shift_en  = 1'b1;
                left_next = left_reg - 1'b1;
                if (!cur_head[PRIO_BIT]) begin
                    seen_next = seen_reg + 1'b1;
                end
                if (!cur_head[PRIO_BIT] && (seen_reg + 1'b1) == low_reg[cur_idx]) begin
                    // newest low entry: drop it on its pass
                    evict_next = cur_head[LEN_W-1:0];
                    count_next[cur_idx] = count_reg[cur_idx] - 1'b1;
                    low_next[cur_idx]   = low_reg[cur_idx] - 1'b1;
                    total_next[cur_idx] = total_reg[cur_idx]
                        - TOT_W'(cur_head[LEN_W-1:0]);
                end else begin
                    // recirculate the head to the tail
                    wr_en   = 1'b1;
                    wr_idx  = IDX_W'(count_reg[cur_idx] - 1'b1);
                    wr_data = cur_head;
                end
                if (left_reg == CNT_W'(1)) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    wr_en   = 1'b1;
                    wr_data = {1'b1, len_reg};
                    count_next[cur_idx] = count_reg[cur_idx] + 1'b1;
                    total_next[cur_idx] = total_reg[cur_idx] + TOT_W'(len_reg);
                    m_valid_next  = 1'b1;
                    m_status_next = ST_EVICTED;
                    m_evict_next  = evict_reg;
                    m_olen_next   = '0;
                    m_oprio_next  = 1'b0;
                    m_bytes_next  = sat_bytes(total_next[cur_idx]);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
            for (int p = 0; p < NUM_PORTS; p++) begin
                count_reg[p] <= '0;
                low_reg[p]   <= '0;
                total_reg[p] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            low_reg     <= low_next;
            total_reg   <= total_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_byte_limit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        port_reg     <= port_next;
        len_reg      <= len_next;
        evict_reg    <= evict_next;
        left_reg     <= left_next;
        seen_reg     <= seen_next;
        m_status_reg <= m_status_next;
        m_evict_reg  <= m_evict_next;
        m_olen_reg   <= m_olen_next;
        m_oprio_reg  <= m_oprio_next;
        m_bytes_reg  <= m_bytes_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_evicted_length = m_evict_reg;
    assign m_out_length     = m_olen_reg;
    assign m_out_priority   = m_oprio_reg;
    assign m_port_bytes     = m_bytes_reg;

    // ---- assertions --------------------------------------------------------
    a_scan_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (left_reg != '0))
        else $error("rotation pass running with nothing left");

    a_scan_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && state_next == S_SCAN)
            |=> (low_reg[port_reg] != '0))
        else $error("eviction started without a low-priority entry");

    a_low_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (low_reg[port_reg] <= count_reg[port_reg]))
        else $error("low-priority count above entry count");

    a_finish_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && out_free)
            |=> (m_valid && m_status == ST_EVICTED && state_reg == S_IDLE))
        else $error("eviction finished without its result word");
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the priority push-out port queues.
// ----------------------------------------------------------------------------
// A shadow of the per-port queues, byte totals and byte limit predicts the
// result word of every accepted input word. The predictions wait in a FIFO,
// and a checker compares each accepted result word with the oldest one, field
// by field. Directed tests cover the empty queue, zero and maximum lengths,
// eviction, a long push-out search and the limit extremes; random phases then
// mix enqueues and dequeues under several byte limits. The sender works in
// bursts with gaps and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
    import ppq_pkg::*;

    localparam int NPORT      = DEF_NUM_PORTS;
    localparam int DEPTH      = DEF_QUEUE_DEPTH;
    localparam int STALL_LIMIT = 50000;
    localparam int SEARCH_LEN  = 40;

    typedef struct packed {
        status_t              status;
        logic [LEN_W-1:0]     evicted_length;
        logic [LEN_W-1:0]     out_length;
        logic                 out_priority;
        logic [LIMIT_W-1:0]   port_bytes;
    } result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [LIMIT_W-1:0]   cfg_byte_limit = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_mode = 1'b0;
    logic [PORT_W-1:0]    s_port = '0;
    logic [LEN_W-1:0]     s_pkt_length = '0;
    logic                 s_pkt_priority = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [LEN_W-1:0]     m_evicted_length;
    logic [LEN_W-1:0]     m_out_length;
    logic                 m_out_priority;
    logic [LIMIT_W-1:0]   m_port_bytes;

    // shadow state: entries hold {priority, length}
    logic [ENTRY_W-1:0]   shadow_q[NPORT][$];
    logic [LIMIT_W+1:0]   shadow_bytes[NPORT];
    logic [LIMIT_W-1:0]   shadow_limit;
    result_t              pending_results[$];

    int  errors = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    bit  stall_random = 1'b1;

    priority_pushout_port_queues_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_byte_limit   (cfg_byte_limit),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_port           (s_port),
        .s_pkt_length     (s_pkt_length),
        .s_pkt_priority   (s_pkt_priority),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_evicted_length (m_evicted_length),
        .m_out_length     (m_out_length),
        .m_out_priority   (m_out_priority),
        .m_port_bytes     (m_port_bytes)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Work out the result word of one accepted input word and update the shadow.
    function automatic result_t queue_step(logic mode, logic [PORT_W-1:0] port,
                                           logic [LEN_W-1:0] len, logic prio);
        result_t r;
        int k;
        r = '{ST_QUEUED, '0, '0, 1'b0, '0};
        if (mode) begin
            if (shadow_q[port].size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status = ST_DEQUEUED;
                r.out_length = shadow_q[port][0][LEN_W-1:0];
                r.out_priority = shadow_q[port][0][PRIO_BIT];
                shadow_bytes[port] -= r.out_length;
                void'(shadow_q[port].pop_front());
            end
        end else if (shadow_bytes[port] + len <= shadow_limit) begin
            if (shadow_q[port].size() >= DEPTH) begin
                r.status = ST_DROP_FULL;
            end else begin
                shadow_q[port].push_back({prio, len});
                shadow_bytes[port] += len;
            end
        end else if (!prio) begin
            r.status = ST_DROP_LIMIT;
        end else begin
            r.status = ST_DROP_LIMIT;
            // push out the newest low-priority entry, if any
            for (k = shadow_q[port].size() - 1; k >= 0; k--) begin
                if (!shadow_q[port][k][PRIO_BIT]) begin
                    r.status = ST_EVICTED;
                    r.evicted_length = shadow_q[port][k][LEN_W-1:0];
                    shadow_bytes[port] -= r.evicted_length;
                    shadow_q[port].delete(k);
                    shadow_q[port].push_back({prio, len});
                    shadow_bytes[port] += len;
                    break;
                end
            end
        end
        r.port_bytes = (shadow_bytes[port] > MAX_BYTES) ? MAX_BYTES
                                                        : shadow_bytes[port][LIMIT_W-1:0];
        return r;
    endfunction

    // Send one input word, then hold or drop valid according to the burst plan.
    task automatic send_word(logic mode, logic [PORT_W-1:0] port,
                             logic [LEN_W-1:0] len, logic prio);
        int gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_port <= port;
        s_pkt_length <= len;
        s_pkt_priority <= prio;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(queue_step(mode, port, len, prio));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write the byte limit; only called with the block idle.
    task automatic set_byte_limit(logic [LIMIT_W-1:0] value);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_byte_limit <= value;
        do @(posedge aclk); while (!cfg_ready);
        shadow_limit = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random enqueue/dequeue traffic with a given enqueue share in percent.
    task automatic random_traffic(int count, int enq_pct);
        logic [LEN_W-1:0] len;
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 19);
            len = (sel == 0) ? '0 : (sel == 1) ? '1 : LEN_W'($urandom);
            send_word($urandom_range(0, 99) >= enq_pct, PORT_W'($urandom), len,
                      1'($urandom));
        end
    endtask

    task automatic test_empty_and_edges();
        send_word(1'b1, 2'd0, '1, 1'b1);         // dequeue from empty queue
        send_word(1'b0, 2'd0, '0, 1'b0);         // zero-length packet
        send_word(1'b0, 2'd0, '1, 1'b1);
        send_word(1'b0, 2'd3, 11'h555, 1'b0);
        send_word(1'b0, 2'd3, 11'h2AA, 1'b1);
        for (int p = 0; p < NPORT; p++) send_word(1'b1, 2'(p), '0, 1'b0);
        send_word(1'b1, 2'd0, '0, 1'b0);
        send_word(1'b1, 2'd3, '0, 1'b0);
    endtask

    task automatic test_eviction();
        set_byte_limit(24'd3000);
        send_word(1'b0, 2'd1, 11'd1000, 1'b0);
        send_word(1'b0, 2'd1, 11'd500, 1'b1);
        send_word(1'b0, 2'd1, 11'd700, 1'b0);
        send_word(1'b0, 2'd1, 11'd600, 1'b1);
        send_word(1'b0, 2'd1, 11'd900, 1'b0);    // low over limit: drop
        send_word(1'b0, 2'd1, 11'd1500, 1'b1);   // evict newest low, total above limit
        send_word(1'b0, 2'd1, 11'd2047, 1'b1);   // evict the older low entry
        send_word(1'b0, 2'd1, 11'd2047, 1'b1);   // no low entry left: drop
        repeat (4) send_word(1'b1, 2'd1, '0, 1'b0);
        set_byte_limit('0);
        send_word(1'b0, 2'd2, '0, 1'b0);         // zero length still fits
        send_word(1'b0, 2'd2, 11'd1, 1'b1);      // evicts the zero-length low entry
        send_word(1'b0, 2'd2, 11'd1, 1'b0);
        send_word(1'b1, 2'd2, '0, 1'b0);
    endtask

    // Only low entry sits at the head: the push-out walks the whole queue.
    task automatic test_long_search();
        set_byte_limit(MAX_BYTES);
        send_word(1'b0, 2'd2, 11'd100, 1'b0);
        for (int i = 0; i < SEARCH_LEN; i++) send_word(1'b0, 2'd2, 11'd1000, 1'b1);
        set_byte_limit(24'd20000);
        send_word(1'b0, 2'd2, 11'd9, 1'b1);
        for (int i = 0; i < SEARCH_LEN + 2; i++) send_word(1'b1, 2'd2, '0, 1'b0);
    endtask

    task automatic test_random();
        set_byte_limit(LIMIT_RESET);
        random_traffic(120, 60);
        set_byte_limit(24'd4000);
        random_traffic(140, 55);
        set_byte_limit(24'($urandom_range(1, 12000)));
        random_traffic(120, 55);
        set_byte_limit(MAX_BYTES);
        random_traffic(90, 50);
    endtask

    // Receiver stall pattern: random phases alternate with always-ready stretches.
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_random <= ~stall_random;
        m_ready <= stall_random ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word status=%0d", $time, m_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, m_status);
                    errors++;
                end
                if (m_evicted_length !== want.evicted_length) begin
                    $display("%0t: evicted_length exp %0d got %0d", $time,
                             want.evicted_length, m_evicted_length);
                    errors++;
                end
                if (m_out_length !== want.out_length) begin
                    $display("%0t: out_length exp %0d got %0d", $time,
                             want.out_length, m_out_length);
                    errors++;
                end
                if (m_out_priority !== want.out_priority) begin
                    $display("%0t: out_priority exp %0d got %0d", $time,
                             want.out_priority, m_out_priority);
                    errors++;
                end
                if (m_port_bytes !== want.port_bytes) begin
                    $display("%0t: port_bytes exp %0d got %0d", $time,
                             want.port_bytes, m_port_bytes);
                    errors++;
                end
            end
        end
    end

    // Watchdog: abort when no word moves on any channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        shadow_limit = LIMIT_RESET;
        for (int p = 0; p < NPORT; p++) shadow_bytes[p] = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_and_edges();
        test_eviction();
        test_long_search();
        test_random();
        drain_results();
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
